// ----- sv/hcc_pkg.sv -----
// Shared types, constants and helpers for the 3x3 mod-95 Hill cipher core.
package hcc_pkg;

    localparam int unsigned ALPHA_SIZE  = 95;
    localparam int unsigned PAD_SYMBOL  = 33;
    localparam int unsigned FIRST_CHAR  = 32;
    localparam int unsigned LAST_CHAR   = 126;
    localparam int unsigned KEY_W       = 63;
    localparam int unsigned SYM_W       = 7;
    localparam int unsigned PROD_W      = 14;
    localparam int unsigned SUM_W       = 15;
    localparam int unsigned QUOT_W      = 9;
    // floor(2^18 / 95); the quotient estimate is low by at most one
    localparam int unsigned RECIP       = 2759;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned RECIP_W     = 12;
    localparam int unsigned MUL_W       = SUM_W + RECIP_W;

    // Register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_KEY  = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;
    localparam logic [1:0] REG_DROP = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             decrypt;
        logic [1:0]       drop;
    } t_cfg;

    typedef struct packed {
        logic             bad;
        logic             last;
        logic [1:0]       pads;
        logic [1:0]       nres;
        logic [SYM_W-1:0] v0;
        logic [SYM_W-1:0] v1;
        logic [SYM_W-1:0] v2;
    } t_cmd;

    // Key entry idx, reduced into 0..94
    function automatic logic [SYM_W-1:0] key_entry(input logic [KEY_W-1:0] key,
                                                   input logic [3:0] idx);
        logic [SYM_W-1:0] raw;
        raw = key[SYM_W*idx +: SYM_W];
        if (raw >= SYM_W'(ALPHA_SIZE)) begin
            return raw - SYM_W'(ALPHA_SIZE);
        end
        return raw;
    endfunction

endpackage

// ----- sv/hcc_front.sv -----
// Front end: checks characters, gathers symbols into blocks and issues commands.
module hcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  hcc_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output hcc_pkg::t_cmd o_cmd
);
    import hcc_pkg::*;

    logic [SYM_W-1:0] r_buf0, r_buf1;
    logic [SYM_W-1:0] n_buf0, n_buf1;
    logic [1:0]       r_count, n_count;
    logic             accept;
    logic             char_ok;
    logic [SYM_W-1:0] sym;
    logic [7:0]       offs;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign char_ok = (i_char >= 8'(FIRST_CHAR)) && (i_char <= 8'(LAST_CHAR));
    assign offs    = i_char - 8'(FIRST_CHAR);
    assign sym     = offs[SYM_W-1:0];

    always_comb begin
        n_buf0  = r_buf0;
        n_buf1  = r_buf1;
        n_count = r_count;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            if (!char_ok) begin
                // drop the character; a bad last one also ends the message
                o_push      = 1'b1;
                o_cmd.bad   = 1'b1;
                o_cmd.last  = i_last;
                o_cmd.nres  = 2'd1;
                if (i_last) begin
                    n_count = 2'd0;
                end
            end else if (!i_last && r_count < 2'd2) begin
                if (r_count == 2'd0) begin
                    n_buf0 = sym;
                end else begin
                    n_buf1 = sym;
                end
                n_count = r_count + 2'd1;
            end else begin
                o_push     = 1'b1;
                o_cmd.last = i_last;
                o_cmd.v0   = (r_count != 2'd0) ? r_buf0 : sym;
                o_cmd.v1   = (r_count == 2'd2) ? r_buf1 :
                             (r_count == 2'd1) ? sym : SYM_W'(PAD_SYMBOL);
                o_cmd.v2   = (r_count == 2'd2) ? sym : SYM_W'(PAD_SYMBOL);
                o_cmd.pads = 2'd2 - r_count;
                o_cmd.nres = (i_last && i_cfg.decrypt) ? 2'd3 - i_cfg.drop : 2'd3;
                n_count    = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_buf0  <= '0;
            r_buf1  <= '0;
        end else begin
            r_count <= n_count;
            r_buf0  <= n_buf0;
            r_buf1  <= n_buf1;
        end
    end

endmodule

// ----- sv/hcc_queue.sv -----
// Small command queue between the front and back ends.
module hcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output hcc_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import hcc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ----- sv/hcc_back.sv -----
// Back end: unless the output stalls, issues one matrix row per cycle and reduces it mod 95 in a pipeline.
module hcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hcc_pkg::t_cfg i_cfg,
    input  hcc_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_char,
    output logic          o_last,
    output logic          o_bad,
    output logic [1:0]    o_pads
);
    import hcc_pkg::*;

    // command being issued
    t_cmd r_cur;
    logic r_cur_vld;
    logic [1:0] r_row;

    // stage 1: products
    logic              r_s1_vld, r_s1_bad, r_s1_last;
    logic [1:0]        r_s1_pads;
    logic [PROD_W-1:0] r_p0, r_p1, r_p2;
    // stage 2: row sum
    logic              r_s2_vld, r_s2_bad, r_s2_last;
    logic [1:0]        r_s2_pads;
    logic [SUM_W-1:0]  r_s2_sum;
    // stage 3: quotient estimate
    logic              r_s3_vld, r_s3_bad, r_s3_last;
    logic [1:0]        r_s3_pads;
    logic [SUM_W-1:0]  r_s3_sum;
    logic [QUOT_W-1:0] r_s3_q;
    // output register
    logic              r_ov, r_olast, r_obad;
    logic [1:0]        r_opads;
    logic [7:0]        r_ochar;

    logic             adv, last_row, issue;
    logic [SYM_W-1:0] k0, k1, k2;
    logic [MUL_W-1:0] qprod;
    logic [SUM_W-1:0] rem_w;
    logic [7:0]       rem, rem_fix;

    assign adv      = !r_ov || !i_stall;
    assign last_row = (r_row == r_cur.nres - 2'd1);
    assign issue    = r_cur_vld && adv;
    assign o_pop    = !i_empty && (!r_cur_vld || (issue && last_row));

    always_comb begin
        unique case (r_row)
            2'd0: begin
                k0 = key_entry(i_cfg.key, 4'd0);
                k1 = key_entry(i_cfg.key, 4'd1);
                k2 = key_entry(i_cfg.key, 4'd2);
            end
            2'd1: begin
                k0 = key_entry(i_cfg.key, 4'd3);
                k1 = key_entry(i_cfg.key, 4'd4);
                k2 = key_entry(i_cfg.key, 4'd5);
            end
            default: begin
                k0 = key_entry(i_cfg.key, 4'd6);
                k1 = key_entry(i_cfg.key, 4'd7);
                k2 = key_entry(i_cfg.key, 4'd8);
            end
        endcase
    end

    assign qprod   = MUL_W'(r_s2_sum) * MUL_W'(RECIP);
    assign rem_w   = r_s3_sum - SUM_W'(r_s3_q) * SUM_W'(ALPHA_SIZE);
    assign rem     = rem_w[7:0];
    assign rem_fix = (rem >= 8'(ALPHA_SIZE)) ? rem - 8'(ALPHA_SIZE) : rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_row     <= 2'd0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_vld <= 1'b1;
                r_row     <= 2'd0;
            end else if (issue) begin
                if (last_row) begin
                    r_cur_vld <= 1'b0;
                end
                r_row <= r_row + 2'd1;
            end
            if (adv) begin
                r_s1_vld <= issue;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                r_ov     <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_cmd;
        end
        if (adv) begin
            r_s1_bad  <= r_cur.bad;
            r_s1_last <= r_cur.last && last_row;
            r_s1_pads <= (r_cur.last && last_row) ? r_cur.pads : 2'd0;
            r_p0      <= PROD_W'(k0) * PROD_W'(r_cur.v0);
            r_p1      <= PROD_W'(k1) * PROD_W'(r_cur.v1);
            r_p2      <= PROD_W'(k2) * PROD_W'(r_cur.v2);

            r_s2_bad  <= r_s1_bad;
            r_s2_last <= r_s1_last;
            r_s2_pads <= r_s1_pads;
            r_s2_sum  <= SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2);

            r_s3_bad  <= r_s2_bad;
            r_s3_last <= r_s2_last;
            r_s3_pads <= r_s2_pads;
            r_s3_sum  <= r_s2_sum;
            r_s3_q    <= qprod[RECIP_SHIFT +: QUOT_W];

            r_obad    <= r_s3_bad;
            r_olast   <= r_s3_last;
            r_opads   <= r_s3_bad ? 2'd0 : r_s3_pads;
            r_ochar   <= r_s3_bad ? 8'd0 : 8'(FIRST_CHAR) + rem_fix;
        end
    end

    assign o_valid = r_ov;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_bad   = r_obad;
    assign o_pads  = r_opads;

endmodule

// ----- sv/hill_cipher_3x3_mod95_core.sv -----
// Top level of the streaming 3x3 Hill cipher over printable ASCII (mod 95).
//
// The core takes one character per cycle and, at full speed, returns one
// result per cycle. The front end checks each character, buffers symbols
// (code minus 32) and, once three are gathered or the message ends, hands a
// block command to a QUEUE_DEPTH-entry queue. An out-of-range character
// becomes a one-result command with bad_char set and out_char 0; if it is
// marked last, any partial block is discarded. The back end pulls commands
// and issues one key-matrix row per cycle through a four-register pipeline
// (three 7x7 products, row sum, reciprocal quotient estimate, remainder with
// one correction), so a block issues a row per result and a bad character
// one row. That single row-per-cycle pipeline sets the throughput; the
// completing character's command goes through the queue, command register
// and pipeline ahead of its first result. A final partial block is padded
// with symbol 33 ('A') and pad_added reports the pad count on the last
// result. In decrypt mode the last pad_drop results of the final block are
// suppressed (at least one remains) and the last one returned carries
// out_last. Either side may stall on its own: the input stalls only when the
// queue is full, the output holds its item while stalled.
// Registers (64-bit APB, byte address 8*i): 0 key_matrix (nine 7-bit entries,
// row-major, each used mod 95), 1 decrypt_mode, 2 pad_drop (3 saturates to 2).
// Write configuration only while the core is idle.
module hill_cipher_3x3_mod95_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic        o_out_last,
    output logic        o_bad_char,
    output logic [1:0]  o_pad_added,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hcc_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic [1:0] drop_in;

    t_cmd front_cmd, queue_cmd;
    logic front_push, queue_full, queue_empty, back_pop;

    // Register file: decode on paddr[4:3], ignore the byte offset
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign drop_in = (pwdata[1:0] == 2'd3) ? 2'd2 : pwdata[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KEY:  r_cfg.key     <= pwdata[KEY_W-1:0];
                REG_MODE: r_cfg.decrypt <= pwdata[0];
                REG_DROP: r_cfg.drop    <= drop_in;
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY:  prdata = 64'(r_cfg.key);
            REG_MODE: prdata = 64'(r_cfg.decrypt);
            REG_DROP: prdata = 64'(r_cfg.drop);
            default:  prdata = '0;
        endcase
    end

    hcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_char  (i_in_char),
        .i_last  (i_in_last),
        .i_cfg   (r_cfg),
        .i_full  (queue_full),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    hcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    hcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (queue_cmd),
        .i_empty (queue_empty),
        .o_pop   (back_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_char  (o_out_char),
        .o_last  (o_out_last),
        .o_bad   (o_bad_char),
        .o_pads  (o_pad_added)
    );

endmodule

// ----- sv/hcc_checker.sv -----
// Port-level checks for the Hill cipher core, bound to the top level.
module hcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_out_last,
    input logic       o_bad_char,
    input logic [1:0] o_pad_added,
    input logic       pready
);

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_char |-> o_out_char == 8'd0 && o_pad_added == 2'd0)
        else $error("bad item carries a character or pad count");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_char |-> o_out_char >= 8'd32 && o_out_char <= 8'd126)
        else $error("result character outside the printable range");

    a_pads_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |-> o_pad_added == 2'd0)
        else $error("pad count reported before the last item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_out_last))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind hill_cipher_3x3_mod95_core hcc_checker u_hcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_char  (o_out_char),
    .o_out_last  (o_out_last),
    .o_bad_char  (o_bad_char),
    .o_pad_added (o_pad_added),
    .pready      (pready)
);
